[src/i2cm_pkg.sv]
package i2cm_pkg;

  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] send_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] tick_cnt;
    logic [7:0] shift;
    logic       ack;
    logic       scl;
    logic       sda;
    logic       drive;
    logic [7:0] read_hold;
  } eng_state_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_seen;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

[src/i2cm_in_stage.sv]
module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        take_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_axis_tready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.mode      <= s_axis_tuser;
      item_q.send_byte <= s_axis_tdata[7:0];
      item_q.sda_in    <= s_axis_tdata[8];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/i2cm_step.sv]
module i2cm_step
  import i2cm_pkg::*;
(
  input  eng_state_t st_i,
  input  item_t      item_i,
  input  logic [7:0] phase_ticks_i,
  output eng_state_t st_o,
  output result_t    res_o
);

  logic       is_cmd, rej, launch, last_tick, fin;
  logic [7:0] len;
  eng_state_t s;

  always_comb begin
    is_cmd = (item_i.mode >= CMD_START) && (item_i.mode <= CMD_READ_NACK);
    rej    = is_cmd && (st_i.cmd != CMD_IDLE);
    launch = is_cmd && (st_i.cmd == CMD_IDLE);
    fin    = 1'b0;
    len    = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
    s      = st_i;

    if (launch) begin
      s.cmd      = item_i.mode;
      s.phase    = 2'd0;
      s.bit_idx  = 4'd0;
      s.tick_cnt = 8'd0;
      s.shift    = (item_i.mode == CMD_WRITE) ? item_i.send_byte : 8'd0;
    end

    last_tick = ({1'b0, s.tick_cnt} + 9'd1) >= {1'b0, len};

    if (s.cmd != CMD_IDLE) begin
      // drive levels for the current phase
      unique case (s.cmd)
        CMD_START: begin
          s.drive = 1'b1;
          unique case (s.phase)
            2'd0: s.sda = 1'b1;
            2'd1: begin s.scl = 1'b1; s.sda = 1'b1; end
            2'd2: begin s.scl = 1'b1; s.sda = 1'b0; end
            default: begin s.scl = 1'b0; s.sda = 1'b0; end
          endcase
        end
        CMD_STOP: begin
          s.drive = 1'b1;
          unique case (s.phase)
            2'd0: s.sda = 1'b0;
            2'd1: begin s.scl = 1'b1; s.sda = 1'b0; end
            default: begin s.scl = 1'b1; s.sda = 1'b1; end
          endcase
        end
        CMD_WRITE: begin
          if (s.bit_idx < BITS_PER_BYTE) begin
            s.scl   = (s.phase != 2'd0);
            s.sda   = s.shift[7];
            s.drive = 1'b1;
          end else begin
            s.scl   = (s.phase == 2'd1);
            s.drive = (s.phase >= 2'd2);
          end
        end
        default: begin
          if (s.bit_idx < BITS_PER_BYTE) begin
            s.scl   = (s.phase != 2'd0);
            s.drive = 1'b0;
          end else begin
            s.scl   = (s.phase == 2'd1);
            s.sda   = (s.cmd == CMD_READ_NACK);
            s.drive = 1'b1;
          end
        end
      endcase

      // close the phase on its last tick
      if (last_tick) begin
        s.tick_cnt = 8'd0;
        unique case (s.cmd)
          CMD_START: begin
            if (s.phase >= 2'd3) fin = 1'b1;
            else s.phase = s.phase + 2'd1;
          end
          CMD_STOP: begin
            if (s.phase >= 2'd2) fin = 1'b1;
            else s.phase = s.phase + 2'd1;
          end
          default: begin
            if (s.bit_idx < BITS_PER_BYTE) begin
              if (s.phase == 2'd0) begin
                s.phase = 2'd1;
              end else begin
                s.shift   = {s.shift[6:0], (s.cmd != CMD_WRITE) && item_i.sda_in};
                s.phase   = 2'd0;
                s.bit_idx = s.bit_idx + 4'd1;
              end
            end else begin
              if (s.phase == 2'd1 && s.cmd == CMD_WRITE) begin
                s.ack = !item_i.sda_in;
              end
              if (s.phase >= 2'd2) begin
                if (s.cmd != CMD_WRITE) s.read_hold = s.shift;
                fin = 1'b1;
              end else begin
                s.phase = s.phase + 2'd1;
              end
            end
          end
        endcase
        if (fin) begin
          s.cmd     = CMD_IDLE;
          s.phase   = 2'd0;
          s.bit_idx = 4'd0;
        end
      end else begin
        s.tick_cnt = s.tick_cnt + 8'd1;
      end
    end

    st_o               = s;
    res_o.scl_level    = s.scl;
    res_o.sda_level    = s.sda;
    res_o.sda_drive    = s.drive;
    res_o.busy_res     = (s.cmd != CMD_IDLE);
    res_o.done_res     = fin;
    res_o.read_byte    = s.read_hold;
    res_o.ack_seen     = s.ack;
    res_o.rejected     = rej;
  end

endmodule

[src/i2c_master_bit_engine_core.sv]
// I2C master bit engine. Each input transfer is one bus tick: tuser carries the
// command (0 tick, 1 start, 2 stop, 3 write byte, 4 read then ACK, 5 read then
// NACK; 6 and 7 count as ticks), tdata the byte to send and the sampled SDA pin.
// Each input transfer yields exactly one output transfer with the SCL/SDA levels,
// SDA drive enable and status after that tick. Each bus phase lasts phase_ticks
// ticks (0 counts as 1), written through cfg_wr_en_i; the user must write it only
// while no command runs, which the block does not enforce. A command that arrives
// while another runs is flagged as rejected and dropped. One transfer per clock while
// the output accepts, via an input register, the state step and a result register.
module i2c_master_bit_engine_core
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] send_byte, [8] sda_in, [15:9] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] scl_level, [1] sda_level, [2] sda_drive,
                                      // [3] busy_res, [4] done_res, [12:5] read_byte,
                                      // [13] ack_seen, [14] rejected, [15] zero
);

  logic       in_valid, adv;
  item_t      item;
  logic [7:0] phase_ticks_q;
  eng_state_t st_q, st_d;
  result_t    res_d, res_q;
  logic       out_valid_q;

  assign adv = in_valid && (!out_valid_q || m_axis_tready);

  i2cm_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (adv),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  i2cm_step u_step (
    .st_i          (st_q),
    .item_i        (item),
    .phase_ticks_i (phase_ticks_q),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RESET;
    end else if (cfg_wr_en_i) begin
      phase_ticks_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= '{cmd: CMD_IDLE, phase: 2'd0, bit_idx: 4'd0, tick_cnt: 8'd0,
                          shift: 8'd0, ack: 1'b0, scl: 1'b1, sda: 1'b1, drive: 1'b1,
                          read_hold: 8'd0};
      out_valid_q    <= 1'b0;
    end else if (adv) begin
      st_q           <= st_d;
      out_valid_q    <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

endmodule

[src/i2cm_checker.sv]
module i2cm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done reported while still busy");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[3] || m_axis_tdata[4])
    else $error("rejected without a running command");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_chk (.*);

[bench/i2c_master_bit_engine_core_test.sv]
`timescale 1ns / 100ps

module i2c_master_bit_engine_core_test;
  import i2cm_pkg::*;

  localparam logic [2:0] MODE_TICK     = CMD_IDLE;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  class i2c_level_scoreboard;
    logic [7:0] phase_len;
    logic [2:0] cmd;
    logic [2:0] phase;
    logic [3:0] bit_cnt;
    logic [7:0] tick_cnt;
    logic [7:0] shreg;
    logic       ack;
    logic       scl;
    logic       sda;
    logic       drv;
    logic [7:0] rd_hold;
    result_t    pending_levels[$];
    int         errors;
    int         checked;
    int         rejects;
    int         finished;

    function new();
      phase_len = PHASE_TICKS_RESET;
      cmd       = CMD_IDLE;
      phase     = '0;
      bit_cnt   = '0;
      tick_cnt  = '0;
      shreg     = '0;
      ack       = 1'b0;
      scl       = 1'b1;
      sda       = 1'b1;
      drv       = 1'b1;
      rd_hold   = '0;
      errors    = 0;
      checked   = 0;
      rejects   = 0;
      finished  = 0;
    endfunction

    function bit is_busy();
      return cmd != CMD_IDLE;
    endfunction

    function void drive_bus();
      case (cmd)
        CMD_START: begin
          drv = 1'b1;
          case (phase)
            3'd0: sda = 1'b1;
            3'd1: begin
              scl = 1'b1;
              sda = 1'b1;
            end
            3'd2: begin
              scl = 1'b1;
              sda = 1'b0;
            end
            default: begin
              scl = 1'b0;
              sda = 1'b0;
            end
          endcase
        end
        CMD_STOP: begin
          drv = 1'b1;
          case (phase)
            3'd0: sda = 1'b0;
            3'd1: begin
              scl = 1'b1;
              sda = 1'b0;
            end
            default: begin
              scl = 1'b1;
              sda = 1'b1;
            end
          endcase
        end
        CMD_WRITE: begin
          if (bit_cnt < BITS_PER_BYTE) begin
            scl = (phase != 3'd0);
            sda = shreg[7];
            drv = 1'b1;
          end else begin
            scl = (phase == 3'd1);
            drv = (phase >= 3'd2);
          end
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          if (bit_cnt < BITS_PER_BYTE) begin
            scl = (phase != 3'd0);
            drv = 1'b0;
          end else begin
            scl = (phase == 3'd1);
            sda = (cmd == CMD_READ_NACK);
            drv = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function bit close_phase(logic sda_in);
      case (cmd)
        CMD_START: begin
          if (phase >= 3'd3) return 1'b1;
          phase = phase + 3'd1;
          return 1'b0;
        end
        CMD_STOP: begin
          if (phase >= 3'd2) return 1'b1;
          phase = phase + 3'd1;
          return 1'b0;
        end
        CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK: begin
          if (bit_cnt < BITS_PER_BYTE) begin
            if (phase == 3'd0) begin
              phase = 3'd1;
            end else begin
              shreg   = {shreg[6:0], (cmd != CMD_WRITE) && sda_in};
              phase   = 3'd0;
              bit_cnt = bit_cnt + 4'd1;
            end
            return 1'b0;
          end
          if (phase == 3'd1 && cmd == CMD_WRITE) ack = !sda_in;
          if (phase >= 3'd2) begin
            if (cmd != CMD_WRITE) rd_hold = shreg;
            return 1'b1;
          end
          phase = phase + 3'd1;
          return 1'b0;
        end
        default: return 1'b1;
      endcase
    endfunction

    function void note_tick(item_t it);
      result_t    lv;
      bit         rej;
      bit         fin;
      logic [8:0] len;
      rej = 1'b0;
      fin = 1'b0;
      if (it.mode >= CMD_START && it.mode <= CMD_READ_NACK) begin
        if (cmd != CMD_IDLE) begin
          rej = 1'b1;
        end else begin
          cmd      = it.mode;
          phase    = '0;
          bit_cnt  = '0;
          tick_cnt = '0;
          shreg    = (it.mode == CMD_WRITE) ? it.send_byte : 8'h00;
        end
      end
      if (cmd != CMD_IDLE) begin
        len = (phase_len == 8'd0) ? 9'd1 : {1'b0, phase_len};
        drive_bus();
        if ({1'b0, tick_cnt} + 9'd1 >= len) begin
          tick_cnt = '0;
          if (close_phase(it.sda_in)) begin
            fin     = 1'b1;
            cmd     = CMD_IDLE;
            phase   = '0;
            bit_cnt = '0;
          end
        end else begin
          tick_cnt = tick_cnt + 8'd1;
        end
      end
      lv.scl_level = scl;
      lv.sda_level = sda;
      lv.sda_drive = drv;
      lv.busy_res  = (cmd != CMD_IDLE);
      lv.done_res  = fin;
      lv.read_byte = rd_hold;
      lv.ack_seen  = ack;
      lv.rejected  = rej;
      rejects  += rej;
      finished += fin;
      pending_levels.push_back(lv);
    endfunction

    function void check_levels(logic [15:0] word);
      result_t got;
      result_t want;
      string   bad;
      checked++;
      got = word[14:0];
      if (pending_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: output transfer %h with nothing expected", $time, word);
        return;
      end
      want = pending_levels.pop_front();
      bad  = "";
      if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
      if (got.sda_level !== want.sda_level) bad = {bad, " sda_level"};
      if (got.sda_drive !== want.sda_drive) bad = {bad, " sda_drive"};
      if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
      if (got.done_res !== want.done_res) bad = {bad, " done_res"};
      if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
      if (got.ack_seen !== want.ack_seen) bad = {bad, " ack_seen"};
      if (got.rejected !== want.rejected) bad = {bad, " rejected"};
      if (word[15] !== 1'b0) bad = {bad, " pad"};
      if (bad != "") begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch in%s: expected %h, got %h", $time, bad, {1'b0, want}, word);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [7:0]  cfg_wr_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  i2c_level_scoreboard board;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  i2c_master_bit_engine_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // hold off the result side on request so the block backs up
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_levels(m_axis_tdata);
  end

  task automatic send_tick(input logic [2:0] mode, input logic [7:0] data_v, input logic sda_v);
    item_t it;
    it.mode      = mode;
    it.send_byte = data_v;
    it.sda_in    = sda_v;
    if (!no_gaps) begin
      while ($urandom_range(99) < 16) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {7'd0, it.sda_in, it.send_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_tick(it);
    sent++;
  endtask

  task automatic run_command(input logic [2:0] mode, input logic [7:0] data_v, input logic sda_v);
    send_tick(mode, data_v, sda_v);
    while (board.is_busy()) send_tick(MODE_TICK, 8'($urandom), sda_v);
  endtask

  task automatic set_phase_len(input logic [7:0] value);
    while (board.is_busy()) send_tick(MODE_TICK, 8'($urandom), 1'($urandom));
    s_axis_tvalid <= 1'b0;
    while (board.pending_levels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    board.phase_len = value;
  endtask

  task automatic random_traffic(input int count);
    int         stop_at;
    int         pick;
    bit         in_frame;
    logic [2:0] m;
    stop_at  = sent + count;
    in_frame = 1'b0;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (board.is_busy()) begin
        if (pick < 90) m = MODE_TICK;
        else if (pick < 95) m = pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
        else m = 3'($urandom_range(CMD_READ_NACK, CMD_START));
      end else if (pick < 12) begin
        m = (pick < 8) ? MODE_TICK : (pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO);
      end else if (pick < 22) begin
        m = 3'($urandom_range(CMD_READ_NACK, CMD_START));
      end else if (!in_frame) begin
        m = CMD_START;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) m = CMD_WRITE;
        else if (pick < 65) m = CMD_READ_ACK;
        else if (pick < 80) m = CMD_READ_NACK;
        else m = CMD_STOP;
      end
      if (!board.is_busy()) begin
        if (m == CMD_START) in_frame = 1'b1;
        else if (m == CMD_STOP) in_frame = 1'b0;
      end
      send_tick(m, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    board = new();
    rst_ni        <= 1'b0;
    cfg_wr_en_i   <= 1'b0;
    cfg_wr_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_TICK;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(MODE_TICK, 8'h00, 1'b0);
    run_command(CMD_START, 8'h00, 1'b1);
    run_command(CMD_WRITE, 8'hff, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b1);
    run_command(CMD_READ_ACK, 8'hff, 1'b1);
    run_command(CMD_READ_NACK, 8'h00, 1'b0);
    run_command(CMD_STOP, 8'h00, 1'b1);
    send_tick(MODE_SPARE_LO, 8'ha5, 1'b1);
    send_tick(MODE_SPARE_HI, 8'h5a, 1'b0);
    send_tick(CMD_START, 8'h00, 1'b1);
    send_tick(CMD_WRITE, 8'h3c, 1'b0);
    send_tick(CMD_STOP, 8'hc3, 1'b1);
    set_phase_len(8'd0);
    run_command(CMD_WRITE, 8'ha5, 1'b0);
    run_command(CMD_READ_NACK, 8'h5a, 1'b1);

    set_phase_len(8'd1);
    random_traffic(150);
    set_phase_len(8'd2);
    hold_req = 1'b1;
    random_traffic(120);
    set_phase_len(8'd0);
    no_gaps = 1'b1;
    random_traffic(120);
    no_gaps = 1'b0;
    set_phase_len(8'd3);
    random_traffic(80);
    set_phase_len(8'd255);
    run_command(CMD_STOP, 8'($urandom), 1'($urandom));
    set_phase_len(8'd5);
    random_traffic(60);
    set_phase_len(8'd1);
    random_traffic(40);

    s_axis_tvalid <= 1'b0;
    while (board.pending_levels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d ticks driven, %0d results checked, %0d mismatches", sent, board.checked,
             board.errors);
    $display("tb: %0d commands completed, %0d refused while busy, phase lengths 0 to 255",
             board.finished, board.rejects);
    if (board.errors == 0 && board.pending_levels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[i2c_master_bit_engine_core.f]
src/i2cm_pkg.sv
src/i2cm_in_stage.sv
src/i2cm_step.sv
src/i2c_master_bit_engine_core.sv
src/i2cm_checker.sv
bench/i2c_master_bit_engine_core_test.sv
